// ----- rtl/mmp_pkg.sv -----
// ----------------------------------------------------------------------------
// mmp_pkg
// Shared widths, types and helper functions for the minmod-limited octant
// prolongation pipeline.
// ----------------------------------------------------------------------------
package mmp_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DIFF_WIDTH  = VALUE_WIDTH + 1;  // exact one-sided difference
  localparam int SUM_WIDTH   = VALUE_WIDTH + 3;  // exact sum of three slopes
  localparam int QTR_WIDTH   = SUM_WIDTH - 2;    // sum after floor shift by two
  localparam int WIDE_WIDTH  = VALUE_WIDTH + 2;  // child before saturation

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;
  typedef logic signed [QTR_WIDTH-1:0]   qtr_t;
  typedef logic signed [WIDE_WIDTH-1:0]  wide_t;

  localparam value_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // Limited slopes and center value handed from the slope unit to the child unit
  typedef struct packed {
    value_t u;
    diff_t  sx;
    diff_t  sy;
    diff_t  sz;
  } slope_t;

  function automatic diff_t minmod(input diff_t up, input diff_t down);
    diff_t res;
    res = '0;
    if (up > 0 && down > 0) begin
      res = (up < down) ? up : down;
    end else if (up < 0 && down < 0) begin
      res = (up > down) ? up : down;
    end
    return res;
  endfunction

  function automatic value_t saturate(input wide_t v);
    value_t res;
    // fits when the three top bits agree
    if (v[WIDE_WIDTH-1:VALUE_WIDTH-1] == '0 || v[WIDE_WIDTH-1:VALUE_WIDTH-1] == '1) begin
      res = v[VALUE_WIDTH-1:0];
    end else if (v[WIDE_WIDTH-1] == 1'b0) begin
      res = VAL_MAX;
    end else begin
      res = VAL_MIN;
    end
    return res;
  endfunction

  function automatic diff_t widen(input value_t v);
    diff_t res;
    res = {v[VALUE_WIDTH-1], v};
    return res;
  endfunction

endpackage

// ----- rtl/mmp_in_if.sv -----
// ----------------------------------------------------------------------------
// mmp_in_if
// Request channel carrying one parent cell and its six face neighbors.
// ----------------------------------------------------------------------------
interface mmp_in_if import mmp_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t center_value;
  value_t x_minus;
  value_t x_plus;
  value_t y_minus;
  value_t y_plus;
  value_t z_minus;
  value_t z_plus;

  modport source (
    output valid, center_value, x_minus, x_plus, y_minus, y_plus, z_minus, z_plus,
    input  ready
  );
  modport sink (
    input  valid, center_value, x_minus, x_plus, y_minus, y_plus, z_minus, z_plus,
    output ready
  );
endinterface

// ----- rtl/mmp_out_if.sv -----
// ----------------------------------------------------------------------------
// mmp_out_if
// Result channel carrying the eight prolonged child values.
// ----------------------------------------------------------------------------
interface mmp_out_if import mmp_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t child_000;
  value_t child_100;
  value_t child_010;
  value_t child_110;
  value_t child_001;
  value_t child_101;
  value_t child_011;
  value_t child_111;

  modport source (
    output valid, child_000, child_100, child_010, child_110,
           child_001, child_101, child_011, child_111,
    input  ready
  );
  modport sink (
    input  valid, child_000, child_100, child_010, child_110,
           child_001, child_101, child_011, child_111,
    output ready
  );
endinterface

// ----- rtl/mmp_slope.sv -----
// ----------------------------------------------------------------------------
// mmp_slope
// Stages 1-2: one-sided differences per axis, then minmod limiting.
// ----------------------------------------------------------------------------
module mmp_slope import mmp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  mmp_in_if.sink   in_chan,
  output logic     slope_valid,
  input  logic     slope_ready,
  output slope_t   slope
);

  // stage 1 registers
  logic   v1;
  value_t u1;
  diff_t  up_x, dn_x, up_y, dn_y, up_z, dn_z;

  // stage 1 next values
  diff_t  up_x_next, dn_x_next, up_y_next, dn_y_next, up_z_next, dn_z_next;

  logic adv1, adv2;

  assign adv2 = !slope_valid || slope_ready;
  assign adv1 = !v1 || adv2;
  assign in_chan.ready = adv1;

  always_comb begin
    diff_t u_w;
    u_w       = widen(in_chan.center_value);
    up_x_next = widen(in_chan.x_plus) - u_w;
    dn_x_next = u_w - widen(in_chan.x_minus);
    up_y_next = widen(in_chan.y_plus) - u_w;
    dn_y_next = u_w - widen(in_chan.y_minus);
    up_z_next = widen(in_chan.z_plus) - u_w;
    dn_z_next = u_w - widen(in_chan.z_minus);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_chan.valid;
    end
    if (adv1 && in_chan.valid) begin
      u1   <= in_chan.center_value;
      up_x <= up_x_next;
      dn_x <= dn_x_next;
      up_y <= up_y_next;
      dn_y <= dn_y_next;
      up_z <= up_z_next;
      dn_z <= dn_z_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_valid <= 1'b0;
    end else if (adv2) begin
      slope_valid <= v1;
    end
    if (adv2 && v1) begin
      slope.u  <= u1;
      slope.sx <= minmod(up_x, dn_x);
      slope.sy <= minmod(up_y, dn_y);
      slope.sz <= minmod(up_z, dn_z);
    end
  end

endmodule

// ----- rtl/mmp_child.sv -----
// ----------------------------------------------------------------------------
// mmp_child
// Stages 3-4: signed slope sums with floor quarter, then u +/- quarter with
// saturation into the output register.
// ----------------------------------------------------------------------------
module mmp_child import mmp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      slope_valid,
  output logic      slope_ready,
  input  slope_t    slope,
  mmp_out_if.source out_chan
);

  // stage 3 registers
  logic   v3;
  value_t u3;
  qtr_t   qa, qb, qc, qd;   // (x+y+z), (x-y-z), (x-y+z), (x+y-z), each /4 floored

  sum_t   sa, sb, sc, sd;
  wide_t  uw;
  wide_t  qa_w, qb_w, qc_w, qd_w;
  logic   adv3, adv4;

  assign adv4 = !out_chan.valid || out_chan.ready;
  assign adv3 = !v3 || adv4;
  assign slope_ready = adv3;

  always_comb begin
    sum_t xs, ys, zs;
    xs = {{2{slope.sx[DIFF_WIDTH-1]}}, slope.sx};
    ys = {{2{slope.sy[DIFF_WIDTH-1]}}, slope.sy};
    zs = {{2{slope.sz[DIFF_WIDTH-1]}}, slope.sz};
    sa = xs + ys + zs;
    sb = xs - ys - zs;
    sc = xs - ys + zs;
    sd = xs + ys - zs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= slope_valid;
    end
    if (adv3 && slope_valid) begin
      u3 <= slope.u;
      // dropping the two low bits is the arithmetic shift right (floor)
      qa <= sa[SUM_WIDTH-1:2];
      qb <= sb[SUM_WIDTH-1:2];
      qc <= sc[SUM_WIDTH-1:2];
      qd <= sd[SUM_WIDTH-1:2];
    end
  end

  assign uw   = {{2{u3[VALUE_WIDTH-1]}}, u3};
  assign qa_w = {qa[QTR_WIDTH-1], qa};
  assign qb_w = {qb[QTR_WIDTH-1], qb};
  assign qc_w = {qc[QTR_WIDTH-1], qc};
  assign qd_w = {qd[QTR_WIDTH-1], qd};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_chan.valid <= 1'b0;
    end else if (adv4) begin
      out_chan.valid <= v3;
    end
    if (adv4 && v3) begin
      out_chan.child_000 <= saturate(uw - qa_w);
      out_chan.child_111 <= saturate(uw + qa_w);
      out_chan.child_100 <= saturate(uw + qb_w);
      out_chan.child_011 <= saturate(uw - qb_w);
      out_chan.child_010 <= saturate(uw - qc_w);
      out_chan.child_101 <= saturate(uw + qc_w);
      out_chan.child_110 <= saturate(uw + qd_w);
      out_chan.child_001 <= saturate(uw - qd_w);
    end
  end

endmodule

// ----- rtl/minmod_prolongation_octant_unit.sv -----
// ----------------------------------------------------------------------------
// minmod_prolongation_octant_unit
// Minmod-limited linear prolongation of one parent cell into eight children,
// signed Q16.16, four-stage pipeline.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_chan   in   center_value, x/y/z minus/plus neighbors
//  out_chan  out  child_000 .. child_111
//
// One request is taken every cycle while no stall on out_chan backs up the
// pipeline (differences, limiting, slope sums, combine/saturate).
// Synchronous reset clears the stage valid bits only.
// A stall on out_chan backs up stage by stage; each stage still refills
// while the one ahead of it is empty, so no request is lost or repeated.
// ----------------------------------------------------------------------------
module minmod_prolongation_octant_unit import mmp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mmp_in_if.sink    in_chan,
  mmp_out_if.source out_chan
);

  logic   slope_valid;
  logic   slope_ready;
  slope_t slope;

  mmp_slope u_slope (
    .clk         (clk),
    .rst         (rst),
    .in_chan     (in_chan),
    .slope_valid (slope_valid),
    .slope_ready (slope_ready),
    .slope       (slope)
  );

  mmp_child u_child (
    .clk         (clk),
    .rst         (rst),
    .slope_valid (slope_valid),
    .slope_ready (slope_ready),
    .slope       (slope),
    .out_chan    (out_chan)
  );

endmodule
